// File: rtl/core/kpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpa_pkg
// Shared constants and types for the key press auto-repeat core.
// ----------------------------------------------------------------------------
package kpa_pkg;

    localparam int NUM_KEYS = 6;
    localparam int CNT_W    = 8;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_LONG_PRESS_TICKS = 1'b0;
    localparam logic REG_REPEAT_INTERVAL  = 1'b1;

    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd200;
    localparam logic [CNT_W-1:0] REPEAT_RESET     = 8'd50;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_interval;
    } t_kpa_cfg;

endpackage

// File: rtl/core/key_press_autorepeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_autorepeat_core
// Press edge detection with long-press auto-repeat for six active-low keys.
//
// One scan tick per request on the slave stream: s_tdata[5:0] carries the
// key levels, 0 meaning pressed. Each accepted tick yields exactly one result
// on the master stream, held in an output register and valid in the cycle after
// the request is accepted. A new tick is accepted every cycle, also while a
// result waits, as long as the receiver takes that result in the same cycle.
// If the receiver stalls, the result stays put and s_tready drops until it
// is taken. Hold counters, the shared repeat counter and the previous levels
// advance only on an accepted tick, all in one combinational pass.
// The APB port holds long_press_ticks (address 0) and repeat_interval
// (address 4); pready is always high and writes land on the access cycle.
// Synchronous reset restores the default counts (200, 50), marks all keys
// released, clears all counters and empties the output register.
// ----------------------------------------------------------------------------
module key_press_autorepeat_core
    import kpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: [5:0] key_levels, [7:6] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Master stream: [5:0] key_events, [6] any_event, [12:7] long_held,
    // [15:13] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_kpa_cfg            r_cfg;
    logic [NUM_KEYS-1:0] r_prev;
    logic                r_out_valid;
    logic [15:0]         r_out_data;

    logic                accept;
    logic [NUM_KEYS-1:0] levels;
    logic                all_released;
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] rep_events;
    logic [NUM_KEYS-1:0] events;
    logic [15:0]         n_out_data;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_LONG_PRESS_TICKS: prdata = {24'd0, r_cfg.long_press_ticks};
            REG_REPEAT_INTERVAL:  prdata = {24'd0, r_cfg.repeat_interval};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= LONG_PRESS_RESET;
            r_cfg.repeat_interval  <= REPEAT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= pwdata[CNT_W-1:0];
                REG_REPEAT_INTERVAL:  r_cfg.repeat_interval  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready     = !r_out_valid || m_tready;
    assign accept       = s_tvalid && s_tready;
    assign levels       = s_tdata[NUM_KEYS-1:0];
    assign all_released = &levels;

    kpa_hold_bank u_hold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_levels (levels),
        .i_cfg    (r_cfg),
        .o_held   (held)
    );

    kpa_repeat u_repeat (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_all_released (all_released),
        .i_held         (held),
        .i_cfg          (r_cfg),
        .o_events       (rep_events)
    );

    assign events     = (~levels & r_prev) | rep_events;
    assign n_out_data = {3'd0, held, |events, events};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_prev      <= levels;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_tvalid
    ) else $error("accepted tick did not produce a result");

    a_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !s_tready
    ) else $error("input accepted while result stalled");

    a_any_event_matches: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[6] == (|m_tdata[5:0]))
    ) else $error("any_event disagrees with key_events");

    a_held_only_pressed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((m_tdata[12:7] & $past(levels)) == '0)
    ) else $error("released key reported as long-held");

endmodule

// File: rtl/core/kpa_hold_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpa_hold_bank
// Per-key hold counters with saturation and the long-held mask.
// ----------------------------------------------------------------------------
module kpa_hold_bank
    import kpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [NUM_KEYS-1:0] i_levels,
    input  t_kpa_cfg            i_cfg,
    output logic [NUM_KEYS-1:0] o_held
);

    logic [CNT_W-1:0] r_cnt [NUM_KEYS];
    logic [CNT_W-1:0] n_cnt [NUM_KEYS];

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!i_levels[k]) begin
                if (r_cnt[k] < i_cfg.long_press_ticks) begin
                    n_cnt[k] = r_cnt[k] + 1'b1;
                end else begin
                    n_cnt[k] = r_cnt[k];
                end
            end else begin
                n_cnt[k] = '0;
            end
            // A counter left above a lowered count never matches again.
            o_held[k] = !i_levels[k] && (n_cnt[k] == i_cfg.long_press_ticks);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!i_rst_n) begin
                r_cnt[k] <= '0;
            end else if (i_accept) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

endmodule

// File: rtl/core/kpa_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpa_repeat
// Shared repeat counter, advanced once per long-held key in key order.
// ----------------------------------------------------------------------------
module kpa_repeat
    import kpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_all_released,
    input  logic [NUM_KEYS-1:0] i_held,
    input  t_kpa_cfg            i_cfg,
    output logic [NUM_KEYS-1:0] o_events
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt    = i_all_released ? '0 : r_cnt;
        o_events = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (i_held[k]) begin
                if (n_cnt >= i_cfg.repeat_interval) begin
                    n_cnt       = '0;
                    o_events[k] = 1'b1;
                end else begin
                    n_cnt = n_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: dv/tb_key_press_autorepeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_press_autorepeat_core
// Self-checking bench for the key press auto-repeat core. A table of
// directed scan ticks and register writes runs first. Random phases follow,
// each with its own long-press count and repeat interval. Most ticks are held
// key patterns, so that keys reach the long-held state and repeat, and the
// rest are releases and scrambled levels. A predictor computes the expected
// event mask of every accepted tick. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_key_press_autorepeat_core;
    import kpa_pkg::*;

    typedef struct packed {
        logic [NUM_KEYS-1:0] events;
        logic                any_ev;
        logic [NUM_KEYS-1:0] held;
    } t_key_report;

    typedef enum logic [1:0] {
        ROW_SCAN,
        ROW_SET_LONG,
        ROW_SET_REPEAT
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  value;
        logic        typed;
        t_key_report want;
    } t_step;

    localparam int NUM_ROWS   = 30;
    localparam int NUM_PHASES = 6;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h3F;   // [5:0] key_levels, [7:6] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [5:0] key_events, [6] any_event,
                                     // [12:7] long_held, [15:13] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and its copy of the registers.
    logic [NUM_KEYS-1:0] prev_levels = '1;
    logic [CNT_W-1:0]    hold_cnt [NUM_KEYS];
    logic [CNT_W-1:0]    shared_repeat = '0;
    logic [CNT_W-1:0]    long_ticks    = LONG_PRESS_RESET;
    logic [CNT_W-1:0]    rep_interval  = REPEAT_RESET;

    t_key_report pending_reports [$];
    int          mismatches    = 0;
    int          tx_gap_pct    = 20;
    int          rx_gap_pct    = 20;
    int          rx_stall_left = 0;

    t_step      steps [NUM_ROWS];
    logic [7:0] ph_long  [NUM_PHASES] = '{8'd200, 8'd1, 8'd0, 8'd255, 8'd3, 8'd5};
    logic [7:0] ph_rep   [NUM_PHASES] = '{8'd50, 8'd0, 8'd0, 8'd255, 8'd2, 8'd1};
    int         ph_count [NUM_PHASES] = '{260, 120, 80, 330, 150, 160};

    key_press_autorepeat_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // One scan tick of the predictor; advances the predictor state.
    function automatic t_key_report scan_tick(input logic [NUM_KEYS-1:0] levels);
        t_key_report         r;
        logic [NUM_KEYS-1:0] ev;
        logic [NUM_KEYS-1:0] held;
        ev          = ~levels & prev_levels;
        prev_levels = levels;
        held        = '0;
        if (levels == '1) begin
            shared_repeat = '0;
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!levels[k]) begin
                if (hold_cnt[k] < long_ticks) begin
                    hold_cnt[k]++;
                end
            end else begin
                hold_cnt[k] = '0;
            end
            if (!levels[k] && hold_cnt[k] == long_ticks) begin
                held[k] = 1'b1;
            end
        end
        // The shared counter is walked key by key, lowest key first.
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (held[k]) begin
                if (shared_repeat >= rep_interval) begin
                    shared_repeat = '0;
                    ev[k]         = 1'b1;
                end else begin
                    shared_repeat++;
                end
            end
        end
        r.events = ev;
        r.any_ev = |ev;
        r.held   = held;
        return r;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_key_report got;
        t_key_report want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[5:0], m_tdata[6], m_tdata[12:7]};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no request pending: events=%h any=%b held=%h",
                             $realtime, got.events, got.any_ev, got.held);
                end
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: events exp=%h act=%h, any exp=%b act=%b, held exp=%h act=%h",
                                 $realtime, want.events, got.events, want.any_ev, got.any_ev,
                                 want.held, got.held);
                    end
                end
            end
        end
    end

    // Receiver with random stalls.
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
            rx_stall_left = gap_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Sends one scan tick and queues its expected report at acceptance.
    task automatic send_levels(input logic [NUM_KEYS-1:0] levels, input logic typed,
                               input t_key_report want);
        t_key_report predicted;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, levels};
        do @(posedge i_clk); while (!s_tready);
        predicted = scan_tick(levels);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    // Stops sending and waits until every expected report has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [7:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_LONG_PRESS_TICKS) begin
            long_ticks = val;
        end else begin
            rep_interval = val;
        end
    endtask

    // A held key pattern with an occasional flipped bit, or scrambled levels.
    task automatic send_run(input logic [NUM_KEYS-1:0] pattern, input int len,
                            input bit scramble, ref int sent);
        logic [NUM_KEYS-1:0] levels;
        for (int n = 0; n < len; n++) begin
            levels = pattern;
            if (scramble) begin
                levels = NUM_KEYS'($urandom_range(0, 63));
            end else if ($urandom_range(0, 15) == 0) begin
                levels[3'($urandom_range(0, NUM_KEYS - 1))] ^= 1'b1;
            end
            send_levels(levels, 1'b0, '0);
            sent++;
        end
    endtask

    initial begin : stimulus
        int                  sent;
        int                  len;
        int                  pick;
        logic [NUM_KEYS-1:0] pattern;

        steps = '{
            // After reset: long press 200, repeat 50.
            '{ROW_SCAN,       8'h3F, 1'b1, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b1, '{6'h01, 1'b1, 6'h00}},
            '{ROW_SCAN,       8'h00, 1'b1, '{6'h3E, 1'b1, 6'h00}},
            '{ROW_SCAN,       8'h3F, 1'b1, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h2A, 1'b1, '{6'h15, 1'b1, 6'h00}},
            '{ROW_SCAN,       8'h15, 1'b1, '{6'h2A, 1'b1, 6'h00}},
            '{ROW_SCAN,       8'h3F, 1'b1, '{6'h00, 1'b0, 6'h00}},
            // Zero long-press count and zero repeat interval: every pressed
            // key is long-held at once and repeats on every tick.
            '{ROW_SET_LONG,   8'd0,  1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SET_REPEAT, 8'd0,  1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h00, 1'b1, '{6'h3F, 1'b1, 6'h3F}},
            '{ROW_SCAN,       8'h00, 1'b1, '{6'h3F, 1'b1, 6'h3F}},
            '{ROW_SCAN,       8'h3F, 1'b1, '{6'h00, 1'b0, 6'h00}},
            // Count lowered below a running hold counter.
            '{ROW_SET_LONG,   8'd10, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SET_REPEAT, 8'd1,  1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SET_LONG,   8'd2,  1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3F, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3E, 1'b0, '{6'h00, 1'b0, 6'h00}},
            '{ROW_SCAN,       8'h3F, 1'b0, '{6'h00, 1'b0, 6'h00}}
        };
        for (int k = 0; k < NUM_KEYS; k++) begin
            hold_cnt[k] = '0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            case (steps[r].kind)
                ROW_SCAN: begin
                    send_levels(steps[r].value[NUM_KEYS-1:0], steps[r].typed, steps[r].want);
                end
                ROW_SET_LONG: begin
                    write_reg(REG_LONG_PRESS_TICKS, steps[r].value);
                end
                default: begin
                    write_reg(REG_REPEAT_INTERVAL, steps[r].value);
                end
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_LONG_PRESS_TICKS, ph_long[p]);
            write_reg(REG_REPEAT_INTERVAL, ph_rep[p]);
            tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            rx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            sent = 0;
            // Open each phase with all keys held long enough to repeat.
            send_run(6'h00, long_ticks + rep_interval / NUM_KEYS + 4, 1'b0, sent);
            while (sent < ph_count[p]) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    pattern = NUM_KEYS'($urandom_range(0, 63));
                    len     = $urandom_range(1, long_ticks + rep_interval + 8);
                end else if (pick < 85) begin
                    pattern = '1;
                    len     = $urandom_range(1, 3);
                end else begin
                    pattern = '1;
                    len     = $urandom_range(1, 8);
                end
                if (len > ph_count[p] - sent) begin
                    len = ph_count[p] - sent;
                end
                send_run(pattern, len, pick >= 85, sent);
                if ($urandom_range(0, 39) == 0) begin
                    drain();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
